@@ src/gipd_pkg.sv @@
package gipd_pkg;

    localparam int PIX_W   = 8;
    localparam int SCALE_W = 3;
    localparam int DIM_W   = 11;
    localparam int PART_W  = 11;
    // at most two 8-sum stages and two tree levels for k up to 6
    localparam int HSTAGES = 2;
    localparam int HTREE   = 2;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam logic [SCALE_W-1:0] SCALE_RST  = 3'd1;
    localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd480;

    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    // rounding average (a + b + 1) >> 1
    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
        return s[PIX_W:1];
    endfunction

endpackage

@@ src/gipd_cfg.sv @@
module gipd_cfg #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_SCALE_STEPS = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gipd_pkg::APB_AW-1:0]         paddr,
    input  logic [gipd_pkg::APB_DW-1:0]         pwdata,
    output logic [gipd_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    output logic [gipd_pkg::SCALE_W-1:0]        k,
    output logic [$clog2(MAX_WIDTH)-1:0]        w_m1,
    output logic [gipd_pkg::DIM_W-1:0]          h_m1,
    output logic                                restart
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = (WW > gipd_pkg::DIM_W) ? WW : gipd_pkg::DIM_W;

    logic [gipd_pkg::SCALE_W-1:0] scale_reg;
    logic [gipd_pkg::DIM_W-1:0]   width_reg;
    logic [gipd_pkg::DIM_W-1:0]   height_reg;
    logic                         wr;
    gipd_pkg::reg_idx_t           idx;
    logic [LW-1:0]                wmask;
    logic [LW-1:0]                wlim;
    logic [LW-1:0]                weff;
    logic [gipd_pkg::DIM_W-1:0]   hmask;
    logic [gipd_pkg::DIM_W-1:0]   heff;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = gipd_pkg::reg_idx_t'(paddr[gipd_pkg::APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= gipd_pkg::SCALE_RST;
            width_reg  <= gipd_pkg::WIDTH_RST;
            height_reg <= gipd_pkg::HEIGHT_RST;
        end
        else if (wr)
        begin
            case (idx)
                gipd_pkg::REG_SCALE:  scale_reg  <= pwdata[gipd_pkg::SCALE_W-1:0];
                gipd_pkg::REG_WIDTH:  width_reg  <= pwdata[gipd_pkg::DIM_W-1:0];
                gipd_pkg::REG_HEIGHT: height_reg <= pwdata[gipd_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        restart = 1'b0;
        prdata  = '0;
        case (idx)
            gipd_pkg::REG_SCALE:
            begin
                restart = wr;
                prdata  = {{(gipd_pkg::APB_DW-gipd_pkg::SCALE_W){1'b0}}, scale_reg};
            end
            gipd_pkg::REG_WIDTH:
            begin
                restart = wr;
                prdata  = {{(gipd_pkg::APB_DW-gipd_pkg::DIM_W){1'b0}}, width_reg};
            end
            gipd_pkg::REG_HEIGHT:
            begin
                restart = wr;
                prdata  = {{(gipd_pkg::APB_DW-gipd_pkg::DIM_W){1'b0}}, height_reg};
            end
            default: ;
        endcase
    end

    // clamp k, then width and height to whole blocks
    always_comb
    begin
        if (scale_reg == '0)
            k = gipd_pkg::SCALE_W'(1);
        else if (scale_reg > gipd_pkg::SCALE_W'(MAX_SCALE_STEPS))
            k = gipd_pkg::SCALE_W'(MAX_SCALE_STEPS);
        else
            k = scale_reg;

        wmask = (LW'(1) << k) - LW'(1);
        wlim  = LW'(width_reg);
        if (wlim > LW'(MAX_WIDTH))
            wlim = LW'(MAX_WIDTH);
        weff = wlim & ~wmask;
        if (weff == '0)
            weff = LW'(1) << k;
        w_m1 = CW'(weff - LW'(1));

        hmask = (gipd_pkg::DIM_W'(1) << k) - gipd_pkg::DIM_W'(1);
        heff  = height_reg & ~hmask;
        if (heff == '0)
            heff = gipd_pkg::DIM_W'(1) << k;
        h_m1 = heff - gipd_pkg::DIM_W'(1);
    end

endmodule

@@ src/gipd_hpass.sv @@
module gipd_hpass #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_SCALE_STEPS = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [gipd_pkg::SCALE_W-1:0]        k,
    input  logic [$clog2(MAX_WIDTH)-1:0]        w_m1,
    input  logic [gipd_pkg::DIM_W-1:0]          h_m1,
    input  logic                                restart,
    input  logic                                accept,
    input  logic [gipd_pkg::PIX_W-1:0]          in_pixel,
    output logic                                hvalid,
    output logic [gipd_pkg::PIX_W-1:0]          hpix,
    output logic [$clog2(MAX_WIDTH/2)-1:0]      hc,
    output logic [MAX_SCALE_STEPS-1:0]          hrow,
    output logic                                hlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(MAX_WIDTH/2);

    logic [CW-1:0]                 col_reg;
    logic [CW-1:0]                 col_next;
    logic [gipd_pkg::DIM_W-1:0]    row_reg;
    logic [gipd_pkg::DIM_W-1:0]    row_next;
    logic [gipd_pkg::PART_W-1:0]   acc_reg  [gipd_pkg::HSTAGES];
    logic [gipd_pkg::PART_W-1:0]   acc_next [gipd_pkg::HSTAGES];
    logic [gipd_pkg::PIX_W-1:0]    tp_reg   [gipd_pkg::HTREE];
    logic [gipd_pkg::PIX_W-1:0]    tp_next  [gipd_pkg::HTREE];
    logic [1:0]                    n8;
    logic [1:0]                    ntree;
    logic                          col_end;
    logic                          row_end;

    always_comb
    begin
        case (k) inside
            [3'd3:3'd5]: n8 = 2'd1;
            3'd6:        n8 = 2'd2;
            default:     n8 = 2'd0;
        endcase
        case (k) inside
            3'd1, 3'd4: ntree = 2'd1;
            3'd2, 3'd5: ntree = 2'd2;
            default:    ntree = 2'd0;
        endcase
    end

    // 8-sum stages, then the rounding tree; stop at the first unfinished group
    always_comb
    begin
        logic [CW-1:0]               idx;
        logic [gipd_pkg::PART_W-1:0] v;
        logic [gipd_pkg::PART_W-1:0] sum;
        logic [gipd_pkg::PIX_W-1:0]  vp;
        logic                        rdy;
        idx      = col_reg;
        v        = gipd_pkg::PART_W'(in_pixel);
        sum      = '0;
        rdy      = 1'b1;
        acc_next = acc_reg;
        tp_next  = tp_reg;
        for (int t = 0; t < gipd_pkg::HSTAGES; t++)
        begin
            if (rdy && t < n8)
            begin
                sum = acc_reg[t] + v;
                if (idx[2:0] != 3'b111)
                begin
                    acc_next[t] = sum;
                    rdy         = 1'b0;
                end
                else
                begin
                    v           = sum >> 3;
                    acc_next[t] = '0;
                    idx         = idx >> 3;
                end
            end
        end
        vp = v[gipd_pkg::PIX_W-1:0];
        for (int t = 0; t < gipd_pkg::HTREE; t++)
        begin
            if (rdy && t < ntree)
            begin
                if (!idx[0])
                begin
                    tp_next[t] = vp;
                    rdy        = 1'b0;
                end
                else
                begin
                    vp  = gipd_pkg::avg2(tp_reg[t], vp);
                    idx = idx >> 1;
                end
            end
        end
        hvalid = rdy;
        hpix   = vp;
    end

    assign col_end  = (col_reg == w_m1);
    assign row_end  = (row_reg == h_m1);
    assign hlast    = col_end && row_end;
    assign hc       = AW'(col_reg >> k);
    assign hrow     = row_reg[MAX_SCALE_STEPS-1:0];
    assign col_next = col_end ? '0 : col_reg + CW'(1);
    assign row_next = !col_end ? row_reg :
                      (row_end ? '0 : row_reg + gipd_pkg::DIM_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int t = 0; t < gipd_pkg::HSTAGES; t++)
                acc_reg[t] <= '0;
            for (int t = 0; t < gipd_pkg::HTREE; t++)
                tp_reg[t] <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int t = 0; t < gipd_pkg::HSTAGES; t++)
                acc_reg[t] <= '0;
            for (int t = 0; t < gipd_pkg::HTREE; t++)
                tp_reg[t] <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
            tp_reg  <= tp_next;
        end
    end

endmodule

@@ src/gipd_vpass.sv @@
module gipd_vpass #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_SCALE_STEPS = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [gipd_pkg::SCALE_W-1:0]        k,
    input  logic                                load,
    input  logic [gipd_pkg::PIX_W-1:0]          hpix,
    input  logic [$clog2(MAX_WIDTH/2)-1:0]      hc,
    input  logic [MAX_SCALE_STEPS-1:0]          hrow,
    input  logic                                hlast,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [gipd_pkg::PIX_W-1:0]          out_pixel,
    output logic                                frame_end,
    output logic                                busy
);

    localparam int AW         = $clog2(MAX_WIDTH/2);
    localparam int STORE_COLS = MAX_WIDTH / 2;
    localparam int MW         = MAX_SCALE_STEPS * gipd_pkg::PIX_W;

    // one entry per reduced column, one byte per tree level
    logic [MW-1:0]                mem [STORE_COLS];
    logic [MW-1:0]                rdata_reg;
    logic                         s1_valid_reg;
    logic [gipd_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [AW-1:0]                s1_hc_reg;
    logic [MAX_SCALE_STEPS-1:0]   s1_row_reg;
    logic                         s1_last_reg;
    logic [MW-1:0]                wdata;
    logic [gipd_pkg::PIX_W-1:0]   vout;
    logic                         s1_out;
    logic                         s1_adv;
    logic                         wr_en;
    logic                         out_valid_reg;
    logic [gipd_pkg::PIX_W-1:0]   out_pixel_reg;
    logic                         frame_end_reg;

    // walk the levels: fold in pending rows, park the value at the first open level
    always_comb
    begin
        logic [gipd_pkg::PIX_W-1:0] v;
        logic                       done;
        v     = s1_pix_reg;
        done  = 1'b0;
        wdata = rdata_reg;
        for (int t = 0; t < MAX_SCALE_STEPS; t++)
        begin
            if (!done && t < k)
            begin
                if (!s1_row_reg[t])
                begin
                    wdata[t*gipd_pkg::PIX_W +: gipd_pkg::PIX_W] = v;
                    done = 1'b1;
                end
                else
                begin
                    v = gipd_pkg::avg2(rdata_reg[t*gipd_pkg::PIX_W +: gipd_pkg::PIX_W], v);
                end
            end
        end
        vout   = v;
        s1_out = !done;
    end

    assign s1_adv = s1_valid_reg && (!s1_out || !out_valid_reg || !out_stall);
    assign wr_en  = s1_adv && !s1_out;
    assign busy   = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_hc_reg] <= wdata;
        if (load)
        begin
            // forward a write-back to the same column
            if (wr_en && s1_hc_reg == hc)
                rdata_reg <= wdata;
            else
                rdata_reg <= mem[hc];
            s1_pix_reg  <= hpix;
            s1_hc_reg   <= hc;
            s1_row_reg  <= hrow;
            s1_last_reg <= hlast;
        end
        if (s1_adv && s1_out)
        begin
            out_pixel_reg <= vout;
            frame_end_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv && s1_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign frame_end = frame_end_reg;

endmodule

@@ src/gray_image_pow2_downscaler.sv @@
// Gray image downscaler by 2^k in both directions, raster order in and out.
// Input channel: in_valid / in_stall with in_pixel, one beat per pixel.
// Output channel: out_valid / out_stall with out_pixel and frame_end; one
// beat per 2^k x 2^k block, frame_end marks the last beat of a frame.
// Configuration over the APB port: scale_steps at 0x0, frame_width at 0x4,
// frame_height at 0x8. Any register write restarts the frame; write only
// while no beat is in flight.
// Throughput: one input beat per cycle while in_stall is low. Each beat for a
// reduced column reads the row store on the accepting edge; the store stage
// then folds it in and writes it back, unless it completes its block.
// Output path: the beat that completes a block passes from the store stage
// to the output register.
// Reset: k = 1, 640 x 480, counters and horizontal sums cleared. The row
// store is not cleared; every entry is written before it is read.
// Output stall: the output register holds its beat, one more beat waits in
// the store stage, then in_stall rises until the output drains.
module gray_image_pow2_downscaler #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_SCALE_STEPS = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gipd_pkg::PIX_W-1:0]          in_pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gipd_pkg::PIX_W-1:0]          out_pixel,
    output logic                                frame_end,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gipd_pkg::APB_AW-1:0]         paddr,
    input  logic [gipd_pkg::APB_DW-1:0]         pwdata,
    output logic [gipd_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(MAX_WIDTH/2);

    logic [gipd_pkg::SCALE_W-1:0] k;
    logic [CW-1:0]                w_m1;
    logic [gipd_pkg::DIM_W-1:0]   h_m1;
    logic                         restart;
    logic                         accept;
    logic                         hvalid;
    logic [gipd_pkg::PIX_W-1:0]   hpix;
    logic [AW-1:0]                hc;
    logic [MAX_SCALE_STEPS-1:0]   hrow;
    logic                         hlast;
    logic                         busy;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    gipd_cfg #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_SCALE_STEPS (MAX_SCALE_STEPS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .k       (k),
        .w_m1    (w_m1),
        .h_m1    (h_m1),
        .restart (restart)
    );

    gipd_hpass #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_SCALE_STEPS (MAX_SCALE_STEPS)
    ) u_hpass (
        .clk      (clk),
        .rst_n    (rst_n),
        .k        (k),
        .w_m1     (w_m1),
        .h_m1     (h_m1),
        .restart  (restart),
        .accept   (accept),
        .in_pixel (in_pixel),
        .hvalid   (hvalid),
        .hpix     (hpix),
        .hc       (hc),
        .hrow     (hrow),
        .hlast    (hlast)
    );

    gipd_vpass #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_SCALE_STEPS (MAX_SCALE_STEPS)
    ) u_vpass (
        .clk       (clk),
        .rst_n     (rst_n),
        .k         (k),
        .load      (accept && hvalid),
        .hpix      (hpix),
        .hc        (hc),
        .hrow      (hrow),
        .hlast     (hlast),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .frame_end (frame_end),
        .busy      (busy)
    );

endmodule
